// File: src/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX1,
    PH_WAIT_BS,
    PH_WAIT_U,
    PH_HEX2
  } phase_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_B      = 8'h62;
  localparam logic [7:0] CHAR_F      = 8'h66;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_R      = 8'h72;
  localparam logic [7:0] CHAR_T      = 8'h74;
  localparam logic [7:0] CHAR_U      = 8'h75;

  localparam logic [15:0] HIGH_SUR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SUR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SUR_MAX  = 16'hDFFF;

  localparam int QUEUE_DEPTH = 2;

  // One group holds every result that a single input byte causes.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      cnt;
    logic [1:0]      kind;
  } group_t;

  typedef struct packed {
    logic   push;
    group_t grp;
  } push_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } head_t;

endpackage
`default_nettype wire

// File: src/jsu_in_if.sv
`default_nettype none
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// File: src/jsu_out_if.sv
`default_nettype none
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  modport source (output valid, output out_byte, output out_kind, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_kind, input out_last, output ready);
endinterface
`default_nettype wire

// File: src/jsu_front.sv
`default_nettype none
module jsu_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  jsu_in_if.sink              in_ch,
  input  wire logic           q_full,
  output jsu_pkg::push_t      q_push
);

  typedef struct packed {
    jsu_pkg::phase_t ph;
    logic            push;
    logic [7:0]      data;
    logic [1:0]      kind;
    logic            hstart;
  } act_t;

  jsu_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]      hc_r, hc_nxt;
  logic [15:0]     cu_r, cu_nxt;
  logic [9:0]      hh_r, hh_nxt;
  logic            hs_r, hs_nxt;

  logic            accept;
  logic            push_flag;
  jsu_pkg::group_t grp;
  act_t            act;
  logic [7:0]      c;
  logic            hd_ok;
  logic [3:0]      hd_val;
  logic            hx_stop;
  logic [15:0]     hx_code;
  logic            hx_done;

  function automatic jsu_pkg::group_t single(input logic [7:0] d, input logic [1:0] k);
    jsu_pkg::group_t g;
    g         = '0;
    g.data[0] = d;
    g.kind    = k;
    return g;
  endfunction

  function automatic jsu_pkg::group_t enc(input logic [20:0] cp);
    jsu_pkg::group_t g;
    g      = '0;
    g.kind = jsu_pkg::KIND_DATA;
    if (cp < 21'h80) begin
      g.data[0] = cp[7:0];
      g.cnt     = 2'd0;
    end else if (cp < 21'h800) begin
      g.data[0] = {3'b110, cp[10:6]};
      g.data[1] = {2'b10, cp[5:0]};
      g.cnt     = 2'd1;
    end else if (cp < 21'h10000) begin
      g.data[0] = {4'b1110, cp[15:12]};
      g.data[1] = {2'b10, cp[11:6]};
      g.data[2] = {2'b10, cp[5:0]};
      g.cnt     = 2'd2;
    end else begin
      g.data[0] = {5'b11110, cp[20:18]};
      g.data[1] = {2'b10, cp[17:12]};
      g.data[2] = {2'b10, cp[11:6]};
      g.data[3] = {2'b10, cp[5:0]};
      g.cnt     = 2'd3;
    end
    return g;
  endfunction

  function automatic act_t body_fn(input logic [7:0] b);
    act_t a;
    a = '0;
    if (b == jsu_pkg::CHAR_QUOTE || b == jsu_pkg::CHAR_NUL) begin
      a.ph   = jsu_pkg::PH_IDLE;
      a.push = 1'b1;
      a.kind = jsu_pkg::KIND_END;
    end else if (b == jsu_pkg::CHAR_BSLASH) begin
      a.ph = jsu_pkg::PH_ESC;
    end else begin
      a.ph   = jsu_pkg::PH_BODY;
      a.push = 1'b1;
      a.data = b;
      a.kind = jsu_pkg::KIND_DATA;
    end
    return a;
  endfunction

  function automatic act_t esc_fn(input logic [7:0] b);
    act_t a;
    a      = '0;
    a.ph   = jsu_pkg::PH_BODY;
    a.push = 1'b1;
    a.kind = jsu_pkg::KIND_DATA;
    case (b)
      jsu_pkg::CHAR_NUL: begin
        a.ph   = jsu_pkg::PH_IDLE;
        a.kind = jsu_pkg::KIND_END;
      end
      jsu_pkg::CHAR_B: a.data = 8'h08;
      jsu_pkg::CHAR_F: a.data = 8'h0C;
      jsu_pkg::CHAR_N: a.data = 8'h0A;
      jsu_pkg::CHAR_R: a.data = 8'h0D;
      jsu_pkg::CHAR_T: a.data = 8'h09;
      jsu_pkg::CHAR_U: begin
        a.ph     = jsu_pkg::PH_HEX1;
        a.push   = 1'b0;
        a.hstart = 1'b1;
      end
      default: a.data = b;
    endcase
    return a;
  endfunction

  assign c           = in_ch.in_byte;
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    hd_ok  = 1'b1;
    hd_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hd_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hd_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hd_val = 4'(c - 8'h37);
    end else begin
      hd_ok = 1'b0;
    end
  end

  assign hx_stop = hs_r || !hd_ok;
  assign hx_code = (!hs_r && hd_ok) ? {cu_r[11:0], hd_val} : cu_r;
  assign hx_done = (hc_r == 2'd3);

  always_comb begin
    phase_nxt = phase_r;
    hc_nxt    = hc_r;
    cu_nxt    = cu_r;
    hh_nxt    = hh_r;
    hs_nxt    = hs_r;
    push_flag = 1'b0;
    grp       = single(8'h00, jsu_pkg::KIND_DATA);
    act       = '0;
    case (phase_r)
      jsu_pkg::PH_IDLE: begin
        if (c == jsu_pkg::CHAR_QUOTE) begin
          phase_nxt = jsu_pkg::PH_BODY;
        end else begin
          push_flag = 1'b1;
          grp       = single(8'h00, jsu_pkg::KIND_ERR);
        end
      end
      jsu_pkg::PH_BODY, jsu_pkg::PH_WAIT_BS, jsu_pkg::PH_ESC, jsu_pkg::PH_WAIT_U: begin
        if (phase_r == jsu_pkg::PH_WAIT_BS && c == jsu_pkg::CHAR_BSLASH) begin
          phase_nxt = jsu_pkg::PH_WAIT_U;
        end else if (phase_r == jsu_pkg::PH_WAIT_U && c == jsu_pkg::CHAR_U) begin
          phase_nxt = jsu_pkg::PH_HEX2;
          hc_nxt    = 2'd0;
          cu_nxt    = 16'h0000;
          hs_nxt    = 1'b0;
        end else begin
          if (phase_r == jsu_pkg::PH_BODY || phase_r == jsu_pkg::PH_WAIT_BS) begin
            act = body_fn(c);
          end else begin
            act = esc_fn(c);
          end
          phase_nxt = act.ph;
          push_flag = act.push;
          grp       = single(act.data, act.kind);
          if (act.hstart) begin
            hc_nxt = 2'd0;
            cu_nxt = 16'h0000;
            hs_nxt = 1'b0;
          end
        end
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
        if (c == jsu_pkg::CHAR_NUL) begin
          phase_nxt = jsu_pkg::PH_IDLE;
          push_flag = 1'b1;
          grp       = single(8'h00, jsu_pkg::KIND_END);
        end else begin
          hs_nxt = hx_stop;
          cu_nxt = hx_code;
          hc_nxt = hx_done ? hc_r : hc_r + 2'd1;
          if (hx_done) begin
            phase_nxt = jsu_pkg::PH_BODY;
            if (phase_r == jsu_pkg::PH_HEX2) begin
              if (hx_code >= jsu_pkg::LOW_SUR_MIN && hx_code <= jsu_pkg::LOW_SUR_MAX) begin
                push_flag = 1'b1;
                grp       = enc({1'b0, hh_r, hx_code[9:0]} | 21'h10000);
              end
            end else if ((hx_code >= jsu_pkg::LOW_SUR_MIN && hx_code <= jsu_pkg::LOW_SUR_MAX)
                         || hx_code == 16'h0000) begin
              push_flag = 1'b0;
            end else if (hx_code >= jsu_pkg::HIGH_SUR_MIN
                         && hx_code <= jsu_pkg::HIGH_SUR_MAX) begin
              hh_nxt    = hx_code[9:0];
              phase_nxt = jsu_pkg::PH_WAIT_BS;
            end else begin
              push_flag = 1'b1;
              grp       = enc({5'b00000, hx_code});
            end
          end
        end
      end
      default: begin
        phase_nxt = jsu_pkg::PH_IDLE;
        push_flag = 1'b1;
        grp       = single(8'h00, jsu_pkg::KIND_ERR);
      end
    endcase
  end

  assign q_push.push = accept && push_flag;
  assign q_push.grp  = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jsu_pkg::PH_IDLE;
      hc_r    <= 2'd0;
      cu_r    <= 16'h0000;
      hh_r    <= 10'h000;
      hs_r    <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      cu_r    <= cu_nxt;
      hh_r    <= hh_nxt;
      hs_r    <= hs_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/jsu_queue.sv
`default_nettype none
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire jsu_pkg::push_t q_push,
  input  wire logic           pop,
  output logic                full,
  output jsu_pkg::head_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::group_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.grp   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push.push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!q_push.push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/jsu_back.sv
`default_nettype none
module jsu_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire jsu_pkg::head_t head,
  output logic                pop,
  jsu_out_if.source           out_ch
);

  logic [1:0] idx_r, idx_nxt;
  logic       last;
  logic       taken;

  assign last            = (idx_r == head.grp.cnt);
  assign taken           = head.valid && out_ch.ready;
  assign out_ch.valid    = head.valid;
  assign out_ch.out_byte = head.grp.data[idx_r];
  assign out_ch.out_kind = head.grp.kind;
  assign out_ch.out_last = last;
  assign pop             = taken && last;

  always_comb begin
    idx_nxt = idx_r;
    if (taken) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/json_string_unescape_top.sv
// A result enters the result queue when the byte that causes it is accepted and is
// offered from its head. Throughput: one byte per cycle while each byte gives at most
// one result and the output is ready; a multi-byte UTF-8 result holds the output port
// until all its bytes are taken. The front decoder keeps taking bytes until the result
// queue between it and the output serialiser is full. Synchronous active-low reset
// returns the decoder to waiting for an opening quote and empties the queue.
`default_nettype none
module json_string_unescape_top #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  jsu_pkg::push_t q_push;
  jsu_pkg::head_t head;
  logic           q_full;
  logic           pop;

  jsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .full   (q_full),
    .head   (head)
  );

  jsu_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid straight after reset");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_kind != jsu_pkg::KIND_DATA |-> out_ch.out_byte == 8'h00)
    else $error("end or error result carries a non-zero byte");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_kind != jsu_pkg::KIND_DATA |-> out_ch.out_last)
    else $error("end or error result not marked last");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.out_kind == jsu_pkg::KIND_DATA
                      || out_ch.out_kind == jsu_pkg::KIND_END
                      || out_ch.out_kind == jsu_pkg::KIND_ERR))
    else $error("illegal result kind");

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import jsu_pkg::*;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] kind;
    logic       last;
  } decoded_t;

  class unescape_scoreboard;
    decoded_t   decoded_due[$];
    decoded_t   step_out[$];
    phase_t     ph;
    logic [1:0] hex_seen;
    logic [15:0] code_val;
    logic [9:0] pending_high;
    bit         hex_done;
    int         errors;

    function new();
      ph = PH_IDLE;
      hex_seen = '0;
      code_val = '0;
      pending_high = '0;
      hex_done = 1'b0;
      errors = 0;
    endfunction

    function void add_result(logic [7:0] v, logic [1:0] k);
      step_out.push_back('{value: v, kind: k, last: 1'b0});
    endfunction

    function void end_string();
      add_result(8'h00, KIND_END);
      ph = PH_IDLE;
    endfunction

    function void emit_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
        add_result(cp[7:0], KIND_DATA);
      end else if (cp < 21'h800) begin
        add_result({3'b110, cp[10:6]}, KIND_DATA);
        add_result({2'b10, cp[5:0]}, KIND_DATA);
      end else if (cp < 21'h10000) begin
        add_result({4'b1110, cp[15:12]}, KIND_DATA);
        add_result({2'b10, cp[11:6]}, KIND_DATA);
        add_result({2'b10, cp[5:0]}, KIND_DATA);
      end else begin
        add_result({5'b11110, cp[20:18]}, KIND_DATA);
        add_result({2'b10, cp[17:12]}, KIND_DATA);
        add_result({2'b10, cp[11:6]}, KIND_DATA);
        add_result({2'b10, cp[5:0]}, KIND_DATA);
      end
    endfunction

    function void start_hex(phase_t nxt);
      ph = nxt;
      hex_seen = '0;
      code_val = '0;
      hex_done = 1'b0;
    endfunction

    function void body_byte(logic [7:0] c);
      if (c == CHAR_QUOTE || c == CHAR_NUL) begin
        end_string();
      end else if (c == CHAR_BSLASH) begin
        ph = PH_ESC;
      end else begin
        add_result(c, KIND_DATA);
        ph = PH_BODY;
      end
    endfunction

    function void esc_byte(logic [7:0] c);
      ph = PH_BODY;
      case (c)
        CHAR_NUL: end_string();
        CHAR_B: add_result(8'h08, KIND_DATA);
        CHAR_F: add_result(8'h0C, KIND_DATA);
        CHAR_N: add_result(8'h0A, KIND_DATA);
        CHAR_R: add_result(8'h0D, KIND_DATA);
        CHAR_T: add_result(8'h09, KIND_DATA);
        CHAR_U: start_hex(PH_HEX1);
        default: add_result(c, KIND_DATA);
      endcase
    endfunction

    // Only the digits before the first non-hex byte count, but all four bytes are taken.
    function bit take_hex(logic [7:0] c);
      logic [3:0] d;
      bit is_hex;
      is_hex = 1'b1;
      d = '0;
      if (c >= CH_0 && c <= CH_9) d = 4'(c - CH_0);
      else if (c >= CH_LA && c <= CH_LF) d = 4'(c - CH_LA + 8'd10);
      else if (c >= CH_UA && c <= CH_UF) d = 4'(c - CH_UA + 8'd10);
      else is_hex = 1'b0;
      if (!hex_done) begin
        if (!is_hex) hex_done = 1'b1;
        else code_val = {code_val[11:0], d};
      end
      if (hex_seen == 2'd3) return 1'b1;
      hex_seen++;
      return 1'b0;
    endfunction

    function void note_request(logic [7:0] c);
      step_out.delete();
      case (ph)
        PH_IDLE: begin
          if (c == CHAR_QUOTE) ph = PH_BODY;
          else add_result(8'h00, KIND_ERR);
        end
        PH_BODY: body_byte(c);
        PH_ESC: esc_byte(c);
        PH_HEX1: begin
          if (c == CHAR_NUL) begin
            end_string();
          end else if (take_hex(c)) begin
            ph = PH_BODY;
            if (code_val >= HIGH_SUR_MIN && code_val <= HIGH_SUR_MAX) begin
              pending_high = code_val[9:0];
              ph = PH_WAIT_BS;
            end else if (!(code_val >= LOW_SUR_MIN && code_val <= LOW_SUR_MAX) &&
                         code_val != 16'h0000) begin
              emit_utf8({5'b0, code_val});
            end
          end
        end
        PH_WAIT_BS: begin
          if (c == CHAR_BSLASH) ph = PH_WAIT_U;
          else body_byte(c);
        end
        PH_WAIT_U: begin
          if (c == CHAR_U) start_hex(PH_HEX2);
          else esc_byte(c);
        end
        PH_HEX2: begin
          if (c == CHAR_NUL) begin
            end_string();
          end else if (take_hex(c)) begin
            ph = PH_BODY;
            if (code_val >= LOW_SUR_MIN && code_val <= LOW_SUR_MAX)
              emit_utf8(21'h10000 | {1'b0, pending_high, code_val[9:0]});
          end
        end
        default: begin
          ph = PH_IDLE;
          add_result(8'h00, KIND_ERR);
        end
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) decoded_due.push_back(step_out[i]);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [7:0] v, logic [1:0] k, logic l);
      decoded_t want;
      if (decoded_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h kind %0d", v, k));
        return;
      end
      want = decoded_due.pop_front();
      if (v !== want.value)
        report_mismatch($sformatf("out_byte %02h, predicted %02h", v, want.value));
      if (k !== want.kind)
        report_mismatch($sformatf("out_kind %0d, predicted %0d", k, want.kind));
      if (l !== want.last)
        report_mismatch($sformatf("out_last %0d, predicted %0d", l, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   rx_hold;
  int   bytes_sent;
  unescape_scoreboard sb;

  jsu_in_if  in_ch();
  jsu_out_if out_ch();

  json_string_unescape_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Called just after a rising edge; returns at the edge where the request is taken.
  task send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(b);
    bytes_sent++;
  endtask

  task send_unicode(input logic [15:0] v);
    logic [3:0] nib;
    send_byte(CHAR_BSLASH);
    send_byte(CHAR_U);
    for (int i = 3; i >= 0; i--) begin
      nib = v[i * 4 +: 4];
      if (nib < 4'd10) send_byte(CH_0 + 8'(nib));
      else send_byte(($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(nib) - 8'd10);
    end
  endtask

  task send_random_string(input int min_tokens, input int max_tokens);
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) send_byte(8'($urandom));
    send_byte(CHAR_QUOTE);
    repeat ($urandom_range(min_tokens, max_tokens)) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: send_byte(8'($urandom_range(1, 255)));
        5, 6: begin
          send_byte(CHAR_BSLASH);
          case ($urandom_range(0, 6))
            0: b = CHAR_B;
            1: b = CHAR_F;
            2: b = CHAR_N;
            3: b = CHAR_R;
            4: b = CHAR_T;
            5: b = CHAR_QUOTE;
            default: b = 8'($urandom_range(1, 255));
          endcase
          send_byte(b);
        end
        7: send_unicode(16'($urandom_range(1, 16'h007F)));
        8: send_unicode(16'($urandom_range(16'h0080, 16'h07FF)));
        9: send_unicode(16'($urandom_range(16'h0800, 16'hFFFF)));
        10, 11: begin
          send_unicode(16'($urandom_range(HIGH_SUR_MIN, HIGH_SUR_MAX)));
          send_unicode(16'($urandom_range(LOW_SUR_MIN, LOW_SUR_MAX)));
        end
        12: send_unicode($urandom_range(0, 1) ? 16'h0000 :
                         16'($urandom_range(LOW_SUR_MIN, LOW_SUR_MAX)));
        13: begin
          send_unicode(16'($urandom_range(HIGH_SUR_MIN, HIGH_SUR_MAX)));
          case ($urandom_range(0, 2))
            0: send_byte(8'($urandom_range(1, 255)));
            1: begin
              send_byte(CHAR_BSLASH);
              send_byte(8'($urandom_range(1, 255)));
            end
            default: send_unicode($urandom_range(0, 1) ? 16'($urandom_range(0, 16'hDBFF)) :
                                  16'($urandom_range(16'hE000, 16'hFFFF)));
          endcase
        end
        14: begin
          send_byte(CHAR_BSLASH);
          send_byte(CHAR_U);
          repeat (4) begin
            case ($urandom_range(0, 3))
              0: send_byte(CHAR_QUOTE);
              1: send_byte(8'($urandom_range(1, 255)));
              default: send_byte(CH_UA + 8'($urandom_range(0, 5)));
            endcase
          end
        end
        default: begin
          // A string cut short by a NUL after an escape has begun, then reopened.
          case ($urandom_range(0, 3))
            0: send_byte(CHAR_BSLASH);
            1: send_unicode(16'($urandom_range(HIGH_SUR_MIN, HIGH_SUR_MAX)));
            2: begin
              send_unicode(16'($urandom_range(HIGH_SUR_MIN, HIGH_SUR_MAX)));
              send_byte(CHAR_BSLASH);
              if ($urandom_range(0, 1)) send_byte(CHAR_U);
            end
            default: begin
              send_byte(CHAR_BSLASH);
              send_byte(CHAR_U);
            end
          endcase
          repeat ($urandom_range(0, 3)) send_byte(CH_0 + 8'($urandom_range(0, 9)));
          send_byte(CHAR_NUL);
          send_byte(CHAR_QUOTE);
        end
      endcase
    end
    send_byte($urandom_range(0, 3) == 0 ? CHAR_NUL : CHAR_QUOTE);
  endtask

  task wait_drained;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.decoded_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.out_byte, out_ch.out_kind, out_ch.out_last);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("json_string_unescape_top regression: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    idle_pct = 17;
    rx_hold = 0;
    bytes_sent = 0;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h41);
    send_byte(CHAR_QUOTE);
    send_byte(8'hFF);
    send_byte(CHAR_BSLASH);
    send_byte(CHAR_T);
    send_unicode(16'hD83D);
    send_unicode(16'hDE00);
    send_byte(CHAR_NUL);
    send_byte(CHAR_QUOTE);
    send_unicode(16'h20AC);
    send_byte(CHAR_QUOTE);

    while (bytes_sent < 150) send_random_string(0, 8);

    // The result side stalls while requests keep coming, so the block must back up.
    rx_hold = 120;
    idle_pct = 0;
    send_random_string(10, 14);
    idle_pct = 17;
    wait_drained();

    idle_pct = 0;
    while (bytes_sent < 260) send_random_string(0, 8);
    idle_pct = 17;
    while (bytes_sent < 370) send_random_string(0, 8);
    wait_drained();

    if (sb.decoded_due.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.decoded_due.size()));
    if (sb.errors == 0) begin
      $display("json_string_unescape_top regression: pass");
    end else begin
      $display("json_string_unescape_top regression: fail");
    end
    $finish;
  end
endmodule

// File: files.f
src/jsu_pkg.sv
src/jsu_in_if.sv
src/jsu_out_if.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_top.sv
tb/testbench.sv
